// ===== rtl/assert_macros.svh =====
// assertion macros used by the console writer sequencer (tmcw_ctrl)
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/tmcw_pkg.sv =====
// shared types and constants of the text mode console writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tmcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROWV_W = 5;
  localparam int COLV_W = 7;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // apb side
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_IDX_W = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ATTR = '0;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] INIT_ATTR    = 8'h07;
  localparam logic [CELL_W-1:0] INIT_CELL    = {INIT_ATTR, CH_SPACE};

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch the request beat
    logic exec;     // run the request on the cursor and store
    logic copy_rd;  // scroll sweep: read one cell
    logic drain;    // last copy write, then aim at the bottom line
    logic fill;     // write one blank cell
    logic init;     // fill with the power-on blank
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic scroll_now;
    logic sweep_last;
  } sts_t;

endpackage

// ===== rtl/text_mode_console_writer.sv =====
// top level of the text mode console writer
// depends on tmcw_pkg, tmcw_regs, tmcw_ctrl and tmcw_datapath
`timescale 1ns / 1ps
//
// Character-cell console: a ROWS x COLUMNS store of 16-bit cells (attribute
// high byte, character low byte) and a cursor. A request beat is taken at a
// rising edge with start high and busy low: in_req_type selects put char,
// set cursor, clear screen or read cell, the other in_ fields carry its
// operands. Every request returns one result beat, out_strobe high for one
// cycle with out_cursor_pos, out_cell_data and out_scrolled; the receiver
// cannot stall it, so results are never held back.
// Put, set cursor and read run an execute step, then a done step that
// raises the strobe. A put that scrolls walks the store once through the
// single write port, one cell a cycle. Clear fills the store with blanks.
// After reset the block runs a clearing pass over the store with busy
// high, then idles with the cursor at 0,0 and attribute 0x07. The
// attribute register sits at apb address 0 and is to be written only while
// idle by the user; the block itself does not enforce this.
//
module text_mode_console_writer import tmcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROWV_W-1:0] in_row_value,
  input  logic [COLV_W-1:0] in_col_value,
  input  logic [IDX_W-1:0]  in_cell_index,
  output logic              out_strobe,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_scrolled
);

  logic [ATTR_W-1:0] attr;
  cmd_t              cmd;
  sts_t              sts;

  tmcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tmcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  tmcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .attr           (attr),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_row_value   (in_row_value),
    .in_col_value   (in_col_value),
    .in_cell_index  (in_cell_index),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

endmodule

// ===== rtl/tmcw_regs.sv =====
// apb configuration register (attribute byte) of the console writer
// depends on tmcw_pkg
`timescale 1ns / 1ps
module tmcw_regs import tmcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [ATTR_W-1:0] attr
);

  logic [ATTR_W-1:0] attr_r;
  logic              hit;

  assign hit = (paddr[CFG_AW-1:2] == REG_COLOR_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= INIT_ATTR;
    end else if (psel && penable && pwrite && hit) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  assign prdata = hit ? CFG_DW'(attr_r) : '0;
  assign pready = 1'b1;
  assign attr   = attr_r;

endmodule

// ===== rtl/tmcw_ctrl.sv =====
// sequencer of the console writer: request steps, scroll and fill sweeps
// depends on tmcw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmcw_ctrl import tmcw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output logic out_strobe,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.fill = 1'b1;
        cmd.init = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.req == REQ_CLEAR) state_nxt = S_FILL;
        else if (sts.scroll_now)           state_nxt = S_SCROLL;
        else                               state_nxt = S_DONE;
      end
      S_SCROLL: begin
        cmd.copy_rd = 1'b1;
        if (sts.sweep_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  `ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_r), "state register not one-hot")
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "result beat repeated")
  `ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_r == S_EXEC, "accepted beat not run")
  `ASSERT_NEXT(a_scroll_drain, clk, rst_n, (state_r == S_SCROLL) && sts.sweep_last,
    state_r == S_DRAIN, "scroll sweep did not drain")

endmodule

// ===== rtl/tmcw_datapath.sv =====
// cursor registers, request latch, screen memory and sweep counter
// depends on tmcw_pkg; driven by tmcw_ctrl commands
`timescale 1ns / 1ps
module tmcw_datapath import tmcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [ATTR_W-1:0] attr,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROWV_W-1:0] in_row_value,
  input  logic [COLV_W-1:0] in_col_value,
  input  logic [IDX_W-1:0]  in_cell_index,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [COLV_W-1:0] COL_LAST = COLV_W'(COLUMNS - 1);
  localparam logic [ROWV_W-1:0] ROW_LAST = ROWV_W'(ROWS - 1);

  // latched request
  req_t              req_r;
  logic [CHAR_W-1:0] char_r;
  logic [ROWV_W-1:0] rowv_r;
  logic [COLV_W-1:0] colv_r;
  logic [IDX_W-1:0]  idx_r;

  logic [ROWV_W-1:0] cur_row_r;
  logic [COLV_W-1:0] cur_col_r;
  logic [AW-1:0]     cnt_r;
  logic              copy_pend_r;
  logic [AW-1:0]     pend_addr_r;
  logic [CELL_W-1:0] rd_data_r;
  logic              scrolled_r;
  logic              rd_ok_r;
  logic [CELL_W-1:0] screen_r [CELLS];

  logic [AW-1:0]     cur_addr;
  logic [CELL_W-1:0] blank;
  logic [ROWV_W-1:0] row_nxt;
  logic [COLV_W-1:0] col_nxt;
  logic              scroll_now;
  logic              wrap;
  logic              put_we;
  logic [AW-1:0]     put_addr;
  logic [CELL_W-1:0] put_data;
  logic [ROWV_W-1:0] row_sat;
  logic [COLV_W-1:0] col_sat;
  logic              idx_ok;
  logic [AW-1:0]     idx_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  assign cur_addr = AW'(32'(cur_row_r) * 32'(COLUMNS) + 32'(cur_col_r));
  assign blank    = {attr, CH_SPACE};
  assign idx_ok   = (32'(idx_r) < 32'(CELLS));
  assign idx_addr = AW'(32'(idx_r));
  assign row_sat  = (32'(rowv_r) < 32'(ROWS)) ? rowv_r : ROW_LAST;
  assign col_sat  = (32'(colv_r) < 32'(COLUMNS)) ? colv_r : COL_LAST;

  // cursor step for a put
  always_comb begin
    row_nxt    = cur_row_r;
    col_nxt    = cur_col_r;
    scroll_now = 1'b0;
    wrap       = 1'b0;
    put_we     = 1'b0;
    put_addr   = cur_addr;
    put_data   = {attr, char_r};
    if (char_r == CH_BACKSPACE) begin
      put_we   = 1'b1;
      put_data = blank;
      // linear position steps back by one, top-left corner stays
      put_addr = (cur_addr == '0) ? cur_addr : cur_addr - AW'(1);
      priority if (cur_col_r != '0) begin
        col_nxt = cur_col_r - COLV_W'(1);
      end else if (cur_row_r != '0) begin
        row_nxt = cur_row_r - ROWV_W'(1);
        col_nxt = COL_LAST;
      end else begin
        col_nxt = cur_col_r;
      end
    end else begin
      priority if (char_r == CH_NEWLINE) begin
        col_nxt = '0;
        wrap    = 1'b1;
      end else if (char_r == CH_RETURN) begin
        col_nxt = '0;
      end else begin
        put_we = 1'b1;
        if (cur_col_r == COL_LAST) begin
          col_nxt = '0;
          wrap    = 1'b1;
        end else begin
          col_nxt = cur_col_r + COLV_W'(1);
        end
      end
      if (wrap) begin
        if (cur_row_r == ROW_LAST) begin
          scroll_now = 1'b1;
        end else begin
          row_nxt = cur_row_r + ROWV_W'(1);
        end
      end
    end
  end

  assign sts.req        = req_r;
  assign sts.scroll_now = (req_r == REQ_PUT) && scroll_now;
  assign sts.sweep_last = (cnt_r == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      char_r <= in_char_code;
      rowv_r <= in_row_value;
      colv_r <= in_col_value;
      idx_r  <= in_cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cnt_r       <= '0;
      copy_pend_r <= 1'b0;
      scrolled_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      copy_pend_r <= cmd.copy_rd;
      if (cmd.exec) begin
        scrolled_r <= sts.scroll_now;
        rd_ok_r    <= (req_r == REQ_READ) && idx_ok;
        cnt_r      <= (req_r == REQ_CLEAR) ? '0 : AW'(COLUMNS);
        unique case (req_r)
          REQ_PUT: begin
            cur_row_r <= row_nxt;
            cur_col_r <= col_nxt;
          end
          REQ_SET: begin
            cur_row_r <= row_sat;
            cur_col_r <= col_sat;
          end
          REQ_CLEAR: begin
            cur_row_r <= '0;
            cur_col_r <= '0;
          end
          REQ_READ: begin
            cur_row_r <= cur_row_r;
          end
        endcase
      end else if (cmd.drain) begin
        cnt_r <= AW'(CELLS - COLUMNS);
      end else if (cmd.copy_rd || cmd.fill) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  // each copy write lands in the cycle after its read, one line further up
  always_ff @(posedge clk) begin
    pend_addr_r <= cnt_r - AW'(COLUMNS);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = blank;
    priority if (copy_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = rd_data_r;
    end else if (cmd.fill) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = cmd.init ? INIT_CELL : blank;
    end else if (cmd.exec && (req_r == REQ_PUT) && put_we) begin
      mem_we    = 1'b1;
      mem_waddr = put_addr;
      mem_wdata = put_data;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_re    = cmd.copy_rd || (cmd.exec && (req_r == REQ_READ) && idx_ok);
  assign mem_raddr = cmd.copy_rd ? cnt_r : idx_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= screen_r[mem_raddr];
    end
  end

  assign out_cursor_pos = POS_W'(cur_addr);
  assign out_cell_data  = rd_ok_r ? rd_data_r : '0;
  assign out_scrolled   = scrolled_r;

endmodule
